// ----- rtl/rme_pkg.sv -----
`default_nettype none
package rme_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int TAB_LEN           = 24;
    localparam int SQRT_STAGES       = 8;   // two root steps per stage

    localparam int LW = 17;                 // lane operand: Q1.15 plus negation headroom
    localparam int CW = 35;                 // CORDIC x/y: lane scaled by 2^16 plus gain
    localparam int ZW = 26;                 // angle accumulator, degrees * 2^16

    localparam logic [14:0] POLE_RESET = 15'd32702;

    localparam logic signed [17:0] HALF_TURN_7    = 18'sd23040;
    localparam logic signed [17:0] QUARTER_TURN_7 = 18'sd11520;
    localparam logic signed [ZW-1:0] QUARTER_TURN_16 = 26'sd5898240;

    localparam logic [1:0] POLE_NONE  = 2'd0;
    localparam logic [1:0] POLE_NORTH = 2'd1;
    localparam logic [1:0] POLE_SOUTH = 2'd2;

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic logic signed [ZW-1:0] atan_deg16(input int i);
        logic signed [ZW-1:0] t;
        case (i)
            0:       t = 26'sd2949120;
            1:       t = 26'sd1740967;
            2:       t = 26'sd919879;
            3:       t = 26'sd466945;
            4:       t = 26'sd234379;
            5:       t = 26'sd117304;
            6:       t = 26'sd58666;
            7:       t = 26'sd29335;
            8:       t = 26'sd14668;
            9:       t = 26'sd7334;
            10:      t = 26'sd3667;
            11:      t = 26'sd1833;
            12:      t = 26'sd917;
            13:      t = 26'sd458;
            14:      t = 26'sd229;
            15:      t = 26'sd115;
            16:      t = 26'sd57;
            17:      t = 26'sd29;
            18:      t = 26'sd14;
            19:      t = 26'sd7;
            20:      t = 26'sd4;
            21:      t = 26'sd2;
            22:      t = 26'sd1;
            default: t = 26'sd0;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/rme_isqrt.sv -----
`default_nettype none
module rme_isqrt (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [30:0] radicand,
    output logic      [15:0] root
);

    localparam int NS = rme_pkg::SQRT_STAGES;

    logic [31:0] v_reg [0:NS-1];
    logic [31:0] r_reg [0:NS-1];
    logic [31:0] v_c   [0:2*NS];
    logic [31:0] r_c   [0:2*NS];

    // stage s takes steps 2s and 2s+1 from the registers of stage s-1
    always_comb
    begin
        logic [31:0] bitv;
        logic [31:0] sum;
        logic [31:0] vi;
        logic [31:0] ri;
        v_c[0] = {1'b0, radicand};
        r_c[0] = '0;
        for (int k = 0; k < 2*NS; k++)
        begin
            bitv = 32'd1 << (30 - 2*k);
            // take the previous stage's registers at each stage boundary
            if (k % 2 == 0 && k > 0)
            begin
                vi = v_reg[k/2 - 1];
                ri = r_reg[k/2 - 1];
            end
            else
            begin
                vi = v_c[k];
                ri = r_c[k];
            end
            sum = ri + bitv;
            if (vi >= sum)
            begin
                v_c[k+1] = vi - sum;
                r_c[k+1] = (ri >> 1) + bitv;
            end
            else
            begin
                v_c[k+1] = vi;
                r_c[k+1] = ri >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NS; s++)
            begin
                v_reg[s] <= v_c[2*s+2];
                r_reg[s] <= r_c[2*s+2];
            end
        end
    end

    assign root = r_reg[NS-1][15:0];

endmodule
`default_nettype wire

// ----- rtl/rme_cordic.sv -----
`default_nettype none
module rme_cordic #(
    parameter int STAGES = rme_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic signed [rme_pkg::LW-1:0]     y_in,
    input  wire logic signed [rme_pkg::LW-1:0]     x_in,
    output logic signed      [rme_pkg::ZW-1:0]     z_out
);

    localparam int CW = rme_pkg::CW;
    localparam int ZW = rme_pkg::ZW;
    localparam int LW = rme_pkg::LW;

    logic signed [CW-1:0] cx_reg [0:STAGES];
    logic signed [CW-1:0] cy_reg [0:STAGES];
    logic signed [ZW-1:0] z_reg  [0:STAGES];
    logic                 zero_reg [0:STAGES];

    logic signed [CW-1:0] sx, sy, px, py;
    logic signed [ZW-1:0] pz;

    always_comb
    begin
        sx = {{(CW-LW-16){x_in[LW-1]}}, x_in, 16'b0};
        sy = {{(CW-LW-16){y_in[LW-1]}}, y_in, 16'b0};
        px = sx;
        py = sy;
        pz = '0;
        // turn a left-half vector into the right half first
        if (sx < 0)
        begin
            if (sy >= 0)
            begin
                px = sy;
                py = -sx;
                pz = rme_pkg::QUARTER_TURN_16;
            end
            else
            begin
                px = -sy;
                py = sx;
                pz = -rme_pkg::QUARTER_TURN_16;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg[0]   <= px;
            cy_reg[0]   <= py;
            z_reg[0]    <= pz;
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_iter
        logic signed [CW-1:0] dx, dy;
        assign dx = cy_reg[i] >>> i;
        assign dy = cx_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (cy_reg[i] >= 0)
                begin
                    cx_reg[i+1] <= cx_reg[i] + dx;
                    cy_reg[i+1] <= cy_reg[i] - dy;
                    z_reg[i+1]  <= z_reg[i] + rme_pkg::atan_deg16(i);
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] - dx;
                    cy_reg[i+1] <= cy_reg[i] + dy;
                    z_reg[i+1]  <= z_reg[i] - rme_pkg::atan_deg16(i);
                end
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    assign z_out = zero_reg[STAGES] ? '0 : z_reg[STAGES];

endmodule
`default_nettype wire

// ----- rtl/rotation_matrix_to_euler.sv -----
// Rotation matrix to bank / heading / attitude angles.
//
// Input stream s_axis: one word per matrix, seven signed Q1.15 entries
// m00, m02, m10, m11, m12, m20, m22 packed from the lowest bit up.
// Output stream m_axis: bank, heading, attitude in degrees with 7
// fraction bits in tdata, pole case (0 regular, 1 north, 2 south) in tuser.
// APB port: register 0 (byte address 0) is the 15-bit pole threshold.
//
// Throughput is one word per cycle while the output is not stalled. The
// pipeline is the input stage, the cosine multiply, eight
// square-root stages, the CORDIC pre-rotation and its iteration stages,
// and the rounding output register.
//
// Reset empties the pipeline and loads the threshold with 0.998 (32702).
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready falls; nothing is dropped or repeated.
`default_nettype none
module rotation_matrix_to_euler #(
    parameter int CORDIC_STAGES = rme_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // elem_r0c0, elem_r0c2, elem_r1c0, elem_r1c1, elem_r1c2, elem_r2c0, elem_r2c2
    input  wire logic [111:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // bank_deg, heading_deg, attitude_deg, one pad bit
    output logic [47:0]       m_axis_tdata,
    // pole_case
    output logic [1:0]        m_axis_tuser,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int LW = rme_pkg::LW;
    localparam int ZW = rme_pkg::ZW;
    localparam int NS = rme_pkg::SQRT_STAGES;
    localparam int L  = 2 + NS + CORDIC_STAGES + 1;

    typedef struct packed {
        logic signed [LW-1:0] by;
        logic signed [LW-1:0] bx;
        logic signed [LW-1:0] hy;
        logic signed [LW-1:0] hx;
        logic signed [15:0]   m10;
        logic [1:0]           code;
    } side_t;

    // configuration
    logic [14:0] thr_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {17'b0, thr_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= rme_pkg::POLE_RESET;
        else if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
            thr_reg <= pwdata[14:0];
    end

    // pipeline control
    logic         en;
    logic [L-1:0] vld_reg;
    logic         out_vld_reg;

    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[L-2:0], s_axis_tvalid};
            out_vld_reg <= vld_reg[L-1];
        end
    end

    // stage A: unpack, pole decision, lane operands
    logic signed [15:0] m00, m02, m10, m11, m12, m20, m22;
    logic signed [LW-1:0] thr_s, m10_s;
    logic [1:0] code_c;
    side_t a_next, a_reg;

    always_comb
    begin
        m00   = s_axis_tdata[15:0];
        m02   = s_axis_tdata[31:16];
        m10   = s_axis_tdata[47:32];
        m11   = s_axis_tdata[63:48];
        m12   = s_axis_tdata[79:64];
        m20   = s_axis_tdata[95:80];
        m22   = s_axis_tdata[111:96];
        thr_s = {2'b0, thr_reg};
        m10_s = {m10[15], m10};
        if (m10_s > thr_s)
            code_c = rme_pkg::POLE_NORTH;
        else if (m10_s < -thr_s)
            code_c = rme_pkg::POLE_SOUTH;
        else
            code_c = rme_pkg::POLE_NONE;
        a_next.by   = -{m12[15], m12};
        a_next.bx   = {m11[15], m11};
        a_next.m10  = m10;
        a_next.code = code_c;
        if (code_c == rme_pkg::POLE_NONE)
        begin
            a_next.hy = -{m20[15], m20};
            a_next.hx = {m00[15], m00};
        end
        else
        begin
            a_next.hy = {m02[15], m02};
            a_next.hx = {m22[15], m22};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            a_reg <= a_next;
    end

    // stage B: cosine squared
    logic signed [31:0] sq;
    logic signed [32:0] rem_c;
    logic [30:0]        rem_reg;

    assign sq    = a_reg.m10 * a_reg.m10;
    assign rem_c = (33'sd1 <<< 30) - {sq[31], sq};

    always_ff @(posedge clk)
    begin
        if (en)
            rem_reg <= (rem_c < 0) ? 31'd0 : rem_c[30:0];
    end

    // hold the other lanes while the root is worked out
    side_t side_reg [0:NS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= a_reg;
            for (int k = 1; k <= NS; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    logic [15:0] cos_root;

    rme_isqrt u_isqrt (
        .clk      (clk),
        .en       (en),
        .radicand (rem_reg),
        .root     (cos_root)
    );

    // three angle lanes
    logic signed [ZW-1:0] zb, zh, za;
    logic signed [LW-1:0] ax;

    assign ax = {1'b0, cos_root};

    rme_cordic #(.STAGES(CORDIC_STAGES)) u_bank (
        .clk   (clk),
        .en    (en),
        .y_in  (side_reg[NS].by),
        .x_in  (side_reg[NS].bx),
        .z_out (zb)
    );

    rme_cordic #(.STAGES(CORDIC_STAGES)) u_heading (
        .clk   (clk),
        .en    (en),
        .y_in  (side_reg[NS].hy),
        .x_in  (side_reg[NS].hx),
        .z_out (zh)
    );

    rme_cordic #(.STAGES(CORDIC_STAGES)) u_attitude (
        .clk   (clk),
        .en    (en),
        .y_in  ({side_reg[NS].m10[15], side_reg[NS].m10}),
        .x_in  (ax),
        .z_out (za)
    );

    logic [1:0] code_reg [0:CORDIC_STAGES];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            code_reg[0] <= side_reg[NS].code;
            for (int k = 1; k <= CORDIC_STAGES; k++)
                code_reg[k] <= code_reg[k-1];
        end
    end

    // round half up to 7 fraction bits, then clamp
    function automatic logic [15:0] to_deg7(input logic signed [ZW-1:0] a,
                                            input logic signed [17:0] lim);
        logic signed [ZW:0] s;
        logic signed [17:0] r;
        s = {a[ZW-1], a} + 27'sd256;
        r = s[ZW:9];
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r[15:0];
    endfunction

    logic [15:0] bank_next, heading_next, att_full;
    logic [14:0] att_next;
    logic [15:0] bank_reg, heading_reg;
    logic [14:0] att_reg;
    logic [1:0]  pole_reg;
    logic [1:0]  code_out;

    always_comb
    begin
        code_out     = code_reg[CORDIC_STAGES];
        heading_next = to_deg7(zh, rme_pkg::HALF_TURN_7);
        att_full     = to_deg7(za, rme_pkg::QUARTER_TURN_7);
        case (code_out)
            rme_pkg::POLE_NORTH:
            begin
                bank_next = '0;
                att_next  = rme_pkg::QUARTER_TURN_7[14:0];
            end
            rme_pkg::POLE_SOUTH:
            begin
                bank_next = '0;
                att_next  = 15'(-rme_pkg::QUARTER_TURN_7);
            end
            default:
            begin
                bank_next = to_deg7(zb, rme_pkg::HALF_TURN_7);
                att_next  = att_full[14:0];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bank_reg    <= bank_next;
            heading_reg <= heading_next;
            att_reg     <= att_next;
            pole_reg    <= code_out;
        end
    end

    assign m_axis_tdata = {1'b0, att_reg, heading_reg, bank_reg};
    assign m_axis_tuser = pole_reg;

endmodule
`default_nettype wire
